// File: design/wfcd_pkg.sv
// ----------------------------------------------------------------------------
// wfcd_pkg: shared types and constants of the wait-for cycle detector
// Field widths, command codes, default sizes and the result beat struct.
// ----------------------------------------------------------------------------
package wfcd_pkg;

   // default sizes, handed to the top level parameters
   localparam int MAX_THREADS_DEF = 32;
   localparam int MAX_LIST_DEF    = 32;

   // fixed field widths
   localparam int TID_W   = 5;
   localparam int TOTAL_W = 6;
   localparam int CAP_W   = 6;

   // capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   // request action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_RUN   = 1'b1;

   // one result beat
   typedef struct packed {
      logic [TID_W-1:0]   found_thread;
      logic               entry_valid;
      logic [TOTAL_W-1:0] total_found;
      logic               last_entry;
   } rsp_beat_type;

   // engine to output register
   typedef struct packed {
      logic         load;
      rsp_beat_type beat;
   } emit_type;

endpackage

// File: design/wfcd_ifs.sv
// ----------------------------------------------------------------------------
// wfcd_ifs: request and response channels of the wait-for cycle detector
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wfcd_req_if
   import wfcd_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [TID_W-1:0] thread_id;
   logic             is_waiting;
   logic [TID_W-1:0] holder_id;

   modport source (output valid, action, thread_id, is_waiting, holder_id, input ready);
   modport sink   (input valid, action, thread_id, is_waiting, holder_id, output ready);
endinterface

interface wfcd_rsp_if
   import wfcd_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [TID_W-1:0]   found_thread;
   logic               entry_valid;
   logic [TOTAL_W-1:0] total_found;
   logic               last_entry;

   modport source (output valid, found_thread, entry_valid, total_found, last_entry,
                   input ready);
   modport sink   (input valid, found_thread, entry_valid, total_found, last_entry,
                   output ready);
endinterface

// File: design/wfcd_ram.sv
// ----------------------------------------------------------------------------
// wfcd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wfcd_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/wfcd_outreg.sv
// ----------------------------------------------------------------------------
// wfcd_outreg: response output register
// Holds one result beat until the sink takes it; frees the slot on a handshake.
// ----------------------------------------------------------------------------
module wfcd_outreg
   import wfcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  emit_type   emit,
   output logic       slot_free,
   wfcd_rsp_if.source rsp_chan
);

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff, beat_in;

   // slot can take a new beat when empty or being drained this cycle
   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (emit.load) begin
         valid_in = 1'b1;
         beat_in  = emit.beat;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.found_thread = beat_ff.found_thread;
   assign rsp_chan.entry_valid  = beat_ff.entry_valid;
   assign rsp_chan.total_found  = beat_ff.total_found;
   assign rsp_chan.last_entry   = beat_ff.last_entry;

endmodule

// File: design/wfcd_engine.sv
// ----------------------------------------------------------------------------
// wfcd_engine: wait table and scan sequencer
// Owns the wait flags, the holder table and the collected list; walks holder
// chains one step at a time through a single compare unit and list read port.
// ----------------------------------------------------------------------------
module wfcd_engine
   import wfcd_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF,
   parameter int MAX_LIST    = MAX_LIST_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CAP_W-1:0] list_capacity,
   input  logic             slot_free,
   output emit_type         emit,
   wfcd_req_if.sink         req_chan
);

   localparam int TA_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int LA_W = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
   localparam int CW   = $clog2(MAX_LIST + 1);
   localparam logic [TA_W-1:0] LAST_T = TA_W'(MAX_THREADS - 1);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_TCHK  = 11'b000_0000_0010,
      S_SKRD  = 11'b000_0000_0100,
      S_SKCMP = 11'b000_0000_1000,
      S_HRD   = 11'b000_0001_0000,
      S_HCAP  = 11'b000_0010_0000,
      S_CHAIN = 11'b000_0100_0000,
      S_CYRD  = 11'b000_1000_0000,
      S_CYCMP = 11'b001_0000_0000,
      S_EMRD  = 11'b010_0000_0000,
      S_EMLD  = 11'b100_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [TA_W-1:0]  t_ff, t_in;
   logic [TA_W-1:0]  cur_ff, cur_in;
   logic [TID_W-1:0] holder_ff, holder_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    cap_ff, cap_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    k_ff, k_in;
   logic             flags_ff [MAX_THREADS];

   logic             req_fire;
   logic             tid_ok;
   logic             tab_we;
   logic             holder_waits;
   logic [TID_W-1:0] hold_rdata;
   logic [TID_W-1:0] list_rdata;
   logic             list_we;
   logic [LA_W-1:0]  list_raddr;
   logic [CW-1:0]    cap_sat;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign tid_ok         = 32'(req_chan.thread_id) < 32'(MAX_THREADS);
   assign tab_we         = req_fire && (req_chan.action == ACT_WRITE) && tid_ok;

   // capacity clipped to the list size
   assign cap_sat = (32'(list_capacity) > 32'(MAX_LIST)) ? CW'(MAX_LIST)
                                                        : CW'(list_capacity);

   // current holder waits on a lock itself
   assign holder_waits = (32'(holder_ff) < 32'(MAX_THREADS)) &&
                         flags_ff[TA_W'(holder_ff)];

   // list read address: emit index while draining, compare index otherwise
   assign list_raddr = ((state_ff == S_EMRD) || (state_ff == S_EMLD)) ? k_ff[LA_W-1:0]
                                                                      : i_ff[LA_W-1:0];
   assign list_we    = (state_ff == S_CYRD) && (i_ff == idx_ff) && (idx_ff < cap_ff);

   wfcd_ram #(.WIDTH(TID_W), .DEPTH(MAX_THREADS)) u_hold_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (TA_W'(req_chan.thread_id)),
      .wr_data (req_chan.holder_id),
      .rd_addr (cur_ff),
      .rd_data (hold_rdata)
   );

   wfcd_ram #(.WIDTH(TID_W), .DEPTH(MAX_LIST)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (idx_ff[LA_W-1:0]),
      .wr_data (holder_ff),
      .rd_addr (list_raddr),
      .rd_data (list_rdata)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      cur_in    = cur_ff;
      holder_in = holder_ff;
      count_in  = count_ff;
      cap_in    = cap_ff;
      idx_in    = idx_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      emit      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_chan.action == ACT_RUN)) begin
               cap_in   = cap_sat;
               count_in = '0;
               t_in     = '0;
               state_in = S_TCHK;
            end
         end
         S_TCHK: begin
            if (!flags_ff[t_ff]) begin
               state_in = S_EMRD;
            end else if (count_ff == '0) begin
               cur_in   = t_ff;
               idx_in   = count_ff;
               state_in = S_HRD;
            end else begin
               i_in     = '0;
               state_in = S_SKRD;
            end
         end
         S_SKRD: begin
            state_in = S_SKCMP;
         end
         S_SKCMP: begin
            if (32'(list_rdata) == 32'(t_ff)) begin
               state_in = S_EMRD;
            end else if (i_ff + CW'(1) == count_ff) begin
               cur_in   = t_ff;
               idx_in   = count_ff;
               state_in = S_HRD;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_SKRD;
            end
         end
         S_HRD: begin
            state_in = S_HCAP;
         end
         S_HCAP: begin
            holder_in = hold_rdata;
            state_in  = S_CHAIN;
         end
         S_CHAIN: begin
            if (idx_ff >= cap_ff) begin
               state_in = S_EMRD;
            end else begin
               i_in     = count_ff;
               state_in = S_CYRD;
            end
         end
         S_CYRD: begin
            if (i_ff == idx_ff) begin
               // no repeat in this chain: holder is appended (list_we)
               if (holder_waits) begin
                  idx_in   = idx_ff + CW'(1);
                  cur_in   = TA_W'(holder_ff);
                  state_in = S_HRD;
               end else begin
                  state_in = S_EMRD;
               end
            end else begin
               state_in = S_CYCMP;
            end
         end
         S_CYCMP: begin
            if (list_rdata == holder_ff) begin
               count_in = idx_ff;
               state_in = S_EMRD;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_CYRD;
            end
         end
         S_EMRD: begin
            state_in = S_EMLD;
         end
         S_EMLD: begin
            if (slot_free) begin
               emit.load = 1'b1;
               if (count_ff == '0) begin
                  emit.beat.last_entry = 1'b1;
                  state_in             = S_IDLE;
               end else begin
                  emit.beat.found_thread = list_rdata;
                  emit.beat.entry_valid  = 1'b1;
                  emit.beat.total_found  = TOTAL_W'(count_ff);
                  emit.beat.last_entry   = (k_ff + CW'(1) == count_ff);
                  k_in                   = k_ff + CW'(1);
                  state_in               = (k_ff + CW'(1) == count_ff) ? S_IDLE : S_EMRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // thread scan advance, shared by every path that ends a thread
      if ((state_in == S_EMRD) && (state_ff != S_EMRD) && (state_ff != S_EMLD)) begin
         if (t_ff == LAST_T) begin
            k_in = '0;
         end else begin
            t_in     = t_ff + TA_W'(1);
            state_in = S_TCHK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      t_ff      <= t_in;
      cur_ff    <= cur_in;
      holder_ff <= holder_in;
      cap_ff    <= cap_in;
      idx_ff    <= idx_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
   end

   // wait flags: cleared by reset, written by table beats
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < MAX_THREADS; n++) begin
            flags_ff[n] <= 1'b0;
         end
      end else if (tab_we) begin
         flags_ff[TA_W'(req_chan.thread_id)] <= req_chan.is_waiting;
      end
   end

endmodule

// File: design/wait_for_cycle_detector_top.sv
// ----------------------------------------------------------------------------
// wait_for_cycle_detector_top: wait-for graph deadlock detector
// Table load, chain-walking scan and emission of the collected thread list.
// ----------------------------------------------------------------------------
// A table-write beat (action 0) is accepted whenever the block is idle. A run
// beat (action 1) blocks the request channel until its last result beat is
// loaded: each of the MAX_THREADS threads is checked; a waiting one is compared
// against the already-collected entries, then its chain is walked holder by
// holder, each fetched, compared against the entries of that chain and appended
// if new; then the beats are emitted, stalled while the sink holds off. Every
// compare goes one entry at a time through the single read port of the
// collected-list RAM. The capacity register is sampled when a run beat is
// accepted.
// ----------------------------------------------------------------------------
module wait_for_cycle_detector_top
   import wfcd_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF,
   parameter int MAX_LIST    = MAX_LIST_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata,
   wfcd_req_if.sink         req_chan,
   wfcd_rsp_if.source       rsp_chan
);

   logic [CAP_W-1:0] cap_ff, cap_in;
   emit_type         emit;
   logic             slot_free;

   // list capacity register
   assign cap_in = csr_we ? csr_wdata : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   wfcd_engine #(
      .MAX_THREADS (MAX_THREADS),
      .MAX_LIST    (MAX_LIST)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .list_capacity (cap_ff),
      .slot_free     (slot_free),
      .emit          (emit),
      .req_chan      (req_chan)
   );

   wfcd_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: sim/wait_for_cycle_detector_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wait_for_cycle_detector_top_test: self-checking bench for the deadlock finder
// Loads wait-for tables, fires detection runs and checks every result beat
// against a local model of the chain walk, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module wait_for_cycle_detector_top_test;
   import wfcd_pkg::*;

   localparam int N_THREADS     = MAX_THREADS_DEF;
   localparam int LIST_DEPTH    = MAX_LIST_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 32;
   localparam int HOLD_CYCLES   = 3000;
   localparam int MAX_REPORTS   = 10;

   // one row of the directed table: a capacity write or a request beat
   typedef struct packed {
      logic               cfg;
      logic [CAP_W-1:0]   cap;
      logic               action;
      logic [TID_W-1:0]   tid;
      logic               waiting;
      logic [TID_W-1:0]   holder;
      logic               typed;
      rsp_beat_type       beat;
   } step_row_type;

   function automatic rsp_beat_type beat_of(int id, bit valid, int total, bit last);
      rsp_beat_type b;
      b.found_thread = id[TID_W-1:0];
      b.entry_valid  = valid;
      b.total_found  = total[TOTAL_W-1:0];
      b.last_entry   = last;
      return b;
   endfunction

   function automatic step_row_type row_write(int tid, bit waiting, int holder);
      step_row_type r;
      r         = '0;
      r.action  = ACT_WRITE;
      r.tid     = tid[TID_W-1:0];
      r.waiting = waiting;
      r.holder  = holder[TID_W-1:0];
      return r;
   endfunction

   function automatic step_row_type row_run();
      step_row_type r;
      r        = '0;
      r.action = ACT_RUN;
      return r;
   endfunction

   function automatic step_row_type row_run_typed(rsp_beat_type b);
      step_row_type r;
      r        = '0;
      r.action = ACT_RUN;
      r.typed  = 1'b1;
      r.beat   = b;
      return r;
   endfunction

   function automatic step_row_type row_cap(int v);
      step_row_type r;
      r     = '0;
      r.cfg = 1'b1;
      r.cap = v[CAP_W-1:0];
      return r;
   endfunction

   localparam rsp_beat_type EMPTY_LIST = beat_of(0, 1'b0, 0, 1'b1);

   // directed table
   localparam step_row_type DIRECTED [25] = '{
      row_run_typed(EMPTY_LIST),              // nothing waits after reset
      row_write(0, 1'b1, 0),                  // thread 0 waits on itself
      row_run_typed(beat_of(0, 1'b1, 1, 1'b1)),
      row_write(0, 1'b0, 31),                 // clear it, holder all ones
      row_write(31, 1'b1, 31),                // top thread waits on itself
      row_run_typed(beat_of(31, 1'b1, 1, 1'b1)),
      row_write(5, 1'b1, 6),                  // tail 5 into ring 6 <-> 7
      row_write(6, 1'b1, 7),
      row_write(7, 1'b1, 6),
      row_write(10, 1'b1, 11),                // dangling chain, 11 never waits
      row_run(),
      row_cap(0),                             // zero capacity drops every chain
      row_run_typed(EMPTY_LIST),
      row_cap(1),
      row_run(),
      row_cap(2),
      row_run(),
      row_cap(63),                            // saturates at the list depth
      row_write(20, 1'b1, 31),
      row_run(),
      row_cap(33),
      row_write(31, 1'b0, 0),                 // break the self-loop
      row_run(),
      row_cap(32),
      row_run()
   };

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;
   logic             rsp_hold;

   wfcd_req_if req_bus ();
   wfcd_rsp_if rsp_bus ();

   wait_for_cycle_detector_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // local copy of the wait-for table and the capacity register
   bit               waits_on_lock [N_THREADS];
   logic [TID_W-1:0] lock_holder   [N_THREADS];
   int               capacity;

   rsp_beat_type deadlock_q [$];
   int           mismatches;
   int           items_sent;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           phase;

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // walk the holder chains like the block does and queue the list beats
   function automatic void predict_deadlock_list();
      logic [TID_W-1:0] found [LIST_DEPTH];
      logic [TID_W-1:0] hold;
      int               found_cnt, lim, t, idx, k;
      bit               seen, hit, done;
      lim       = (capacity > LIST_DEPTH) ? LIST_DEPTH : capacity;
      found_cnt = 0;
      for (t = 0; t < N_THREADS; t++) begin
         if (!waits_on_lock[t])
            continue;
         seen = 0;
         for (k = 0; k < found_cnt; k++)
            if (found[k] == t)
               seen = 1;
         if (seen)
            continue;
         hold = lock_holder[t];
         done = 0;
         for (idx = found_cnt; idx < lim && !done; idx++) begin
            hit = 0;
            for (k = found_cnt; k < idx; k++)
               if (found[k] == hold)
                  hit = 1;
            if (hit) begin
               // holder repeats within this chain: keep it
               found_cnt = idx;
               done      = 1;
            end else begin
               found[idx] = hold;
               if (!waits_on_lock[hold])
                  done = 1;
               else
                  hold = lock_holder[hold];
            end
         end
      end
      if (found_cnt == 0)
         deadlock_q.push_back(EMPTY_LIST);
      for (k = 0; k < found_cnt; k++)
         deadlock_q.push_back(beat_of(int'(found[k]), 1'b1, found_cnt,
                                      k == found_cnt - 1));
   endfunction

   function automatic void log_mismatch(string what, rsp_beat_type want, rsp_beat_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: thread %0d/%0d valid %0b/%0b total %0d/%0d last %0b/%0b (exp/act)",
                  $time, what, want.found_thread, got.found_thread, want.entry_valid,
                  got.entry_valid, want.total_found, got.total_found, want.last_entry,
                  got.last_entry);
   endfunction

   // offer one request beat, apply it to the local table once accepted
   task automatic send_beat(input logic act, input logic [TID_W-1:0] tid,
                            input logic waiting, input logic [TID_W-1:0] holder,
                            input logic typed, input rsp_beat_type typed_beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.thread_id  <= tid;
      req_bus.is_waiting <= waiting;
      req_bus.holder_id  <= holder;
      do
         @(posedge clock);
      while (!req_bus.ready);
      if (act == ACT_WRITE) begin
         waits_on_lock[tid] = waiting;
         lock_holder[tid]   = holder;
      end else if (typed) begin
         deadlock_q.push_back(typed_beat);
      end else begin
         predict_deadlock_list();
      end
      items_sent++;
   endtask

   // capacity write, only once the block has drained
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (deadlock_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      capacity   = int'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly rings of distinct threads (with tails) followed by a run, some noise
   task automatic random_traffic(input int budget);
      logic [TID_W-1:0] order [N_THREADS];
      logic [TID_W-1:0] swap;
      int               stop, ring, tails, j, k;
      stop = items_sent + budget;
      while (items_sent < stop) begin
         if ($urandom_range(99) < 75) begin
            for (j = 0; j < N_THREADS; j++)
               order[j] = TID_W'(j);
            for (j = N_THREADS - 1; j > 0; j--) begin
               k        = $urandom_range(j);
               swap     = order[j];
               order[j] = order[k];
               order[k] = swap;
            end
            ring  = ($urandom_range(99) < 85) ? $urandom_range(1, 6)
                                               : $urandom_range(7, N_THREADS);
            tails = (ring < N_THREADS - 2) ? $urandom_range(2) : 0;
            for (j = 0; j < ring; j++)
               send_beat(ACT_WRITE, order[j], 1'b1, order[(j + 1) % ring], 1'b0, '0);
            for (j = ring; j < ring + tails; j++)
               send_beat(ACT_WRITE, order[j], 1'b1, order[$urandom_range(j - 1)], 1'b0, '0);
            // broken ring now and then
            if ($urandom_range(99) < 15)
               send_beat(ACT_WRITE, order[$urandom_range(ring - 1)], 1'b0,
                         TID_W'($urandom_range(31)), 1'b0, '0);
            send_beat(ACT_RUN, TID_W'($urandom_range(31)), 1'($urandom_range(1)),
                      TID_W'($urandom_range(31)), 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 4))
               send_beat(ACT_WRITE, TID_W'($urandom_range(31)), 1'($urandom_range(1)),
                         TID_W'($urandom_range(31)), 1'b0, '0);
            if ($urandom_range(1))
               send_beat(ACT_RUN, TID_W'($urandom_range(31)), 1'($urandom_range(1)),
                         TID_W'($urandom_range(31)), 1'b0, '0);
         end
      end
   endtask

   // result sink: random ready, long hold-off on request
   initial begin : rsp_sink
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long receiver stall while requests keep coming
   initial begin : rsp_holdoff
      rsp_hold <= 1'b0;
      wait (phase == 4);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // result checker
   always @(posedge clock) begin
      rsp_beat_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = beat_of(int'(rsp_bus.found_thread), rsp_bus.entry_valid,
                       int'(rsp_bus.total_found), rsp_bus.last_entry);
         if (deadlock_q.size() == 0) begin
            log_mismatch("unexpected beat", '0, got);
         end else begin
            want = deadlock_q.pop_front();
            if (got.found_thread !== want.found_thread || got.entry_valid !== want.entry_valid
                || got.total_found !== want.total_found || got.last_entry !== want.last_entry)
               log_mismatch("wrong beat", want, got);
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int phase_items [6];
      int i;
      phase_items = '{30, 30, 30, 15, 30, 25};
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_WRITE;
      req_bus.thread_id  <= '0;
      req_bus.is_waiting <= 1'b0;
      req_bus.holder_id  <= '0;
      recv_idle_pct      <= 0;
      send_idle_pct       = 0;
      phase               = 0;
      mismatches          = 0;
      items_sent          = 0;
      capacity            = int'(CAP_RESET);
      for (i = 0; i < N_THREADS; i++) begin
         waits_on_lock[i] = 0;
         lock_holder[i]   = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      for (i = 0; i < $size(DIRECTED); i++) begin
         if (DIRECTED[i].cfg)
            set_capacity(DIRECTED[i].cap);
         else
            send_beat(DIRECTED[i].action, DIRECTED[i].tid, DIRECTED[i].waiting,
                      DIRECTED[i].holder, DIRECTED[i].typed, DIRECTED[i].beat);
      end

      // random part: idling mode changes every two phases, capacity every phase
      for (i = 0; i < 6; i++) begin
         case (i)
            0: set_capacity(CAP_RESET);
            1: set_capacity(CAP_W'($urandom_range(2, 31)));
            2: set_capacity(6'd63);
            3: set_capacity(6'd1);
            4: set_capacity(CAP_W'($urandom_range(3, 40)));
            default: set_capacity(6'd32);
         endcase
         if (i < 2) begin
            send_idle_pct  = 31;
            recv_idle_pct <= 80;
         end else if (i < 4) begin
            send_idle_pct  = 80;
            recv_idle_pct <= 31;
         end else begin
            send_idle_pct  = 0;
            recv_idle_pct <= 0;
         end
         phase = i;
         random_traffic(phase_items[i]);
      end

      // drain
      req_bus.valid <= 1'b0;
      while (deadlock_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatches += deadlock_q.size();
      if (mismatches == 0)
         $display("wait_for_cycle_detector_top: match");
      else
         $display("wait_for_cycle_detector_top: mismatch");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #100ms;
      $display("wait_for_cycle_detector_top: mismatch");
      $finish;
   end

endmodule
